// ===== rtl/core/sexpr_lexer_assert.svh =====
// Assertion macros used by the lexer checker.
`ifndef SEXPR_LEXER_ASSERT_SVH
`define SEXPR_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SXL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SXL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sxl_pkg.sv =====
package sxl_pkg;

  // Result kinds
  localparam logic [3:0] K_CONTENT = 4'd0;
  localparam logic [3:0] K_LPAREN  = 4'd1;
  localparam logic [3:0] K_RPAREN  = 4'd2;
  localparam logic [3:0] K_QUOTE   = 4'd3;
  localparam logic [3:0] K_QUASI   = 4'd4;
  localparam logic [3:0] K_UNQUOTE = 4'd5;
  localparam logic [3:0] K_SPLICE  = 4'd6;
  localparam logic [3:0] K_DOT     = 4'd7;
  localparam logic [3:0] K_STRING  = 4'd8;
  localparam logic [3:0] K_NUMBER  = 4'd9;
  localparam logic [3:0] K_SYMBOL  = 4'd10;
  localparam logic [3:0] K_EOF     = 4'd11;
  localparam logic [3:0] K_UNTERM  = 4'd12;
  localparam logic [3:0] K_TOOLONG = 4'd13;

  // Source characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  content_byte;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [15:0] end_line;
    logic [15:0] end_col;
    logic        last_result;
  } res_t;

  // Up to two results made by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_out_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic ends_word(logic [7:0] c);
    return (c == CH_NUL) || is_space(c) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_QUOTE) || (c == CH_DQUOTE);
  endfunction

endpackage

// ===== rtl/core/sxl_step.sv =====
module sxl_step
  import sxl_pkg::*;
#(
  parameter int MAX_STRING = 1023,
  parameter int POS_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] char_byte,
  output step_out_t step_o
);

  localparam int CntW  = $clog2(MAX_STRING + 1);
  localparam int WideW = (POS_BITS > 16) ? POS_BITS : 16;
  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam logic [POS_BITS-1:0] PosOne = POS_BITS'(1);
  localparam logic [CntW-1:0]     CntMax = CntW'(MAX_STRING);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_WORD    = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_ESCAPE  = 3'd4;
  localparam logic [2:0] M_COMMA   = 3'd5;
  localparam logic [2:0] M_DOT     = 3'd6;

  typedef struct packed {
    logic [2:0]          mode;
    logic [POS_BITS-1:0] cur_line;
    logic [POS_BITS-1:0] cur_col;
    logic [POS_BITS-1:0] tok_line;
    logic [POS_BITS-1:0] tok_col;
    logic [CntW-1:0]     str_cnt;
    logic [1:0]          wlen;
    logic                wminus;
    logic                wnum;
  } lex_state_t;

  function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic logic [15:0] lo16(logic [POS_BITS-1:0] v);
    logic [WideW-1:0] w;
    w = WideW'(v);
    return w[15:0];
  endfunction

  function automatic res_t mk(logic [3:0] kind, logic [7:0] b,
                              logic [POS_BITS-1:0] sl, logic [POS_BITS-1:0] sc,
                              logic [POS_BITS-1:0] el, logic [POS_BITS-1:0] ec);
    res_t r;
    r.kind         = kind;
    r.content_byte = b;
    r.start_line   = lo16(sl);
    r.start_col    = lo16(sc);
    r.end_line     = lo16(el);
    r.end_col      = lo16(ec);
    r.last_result  = 1'b0;
    return r;
  endfunction

  lex_state_t st_r, st_nxt, idle_st;
  logic [POS_BITS-1:0] adv_line, adv_col;
  logic idle_emit, pre_v, sec_v, use_idle;
  res_t idle_res, pre, sec;
  logic [7:0] c, esc_byte;

  assign c = char_byte;

  // cursor after consuming c
  assign adv_line = (c == CH_LF) ? sat_inc(st_r.cur_line) : st_r.cur_line;
  assign adv_col  = (c == CH_LF) ? PosOne : sat_inc(st_r.cur_col);

  assign esc_byte = (c == CH_LOW_N) ? CH_LF : ((c == CH_LOW_T) ? CH_TAB : c);

  // Tokenizing c from idle; also the tail of the paths that end a token before c
  always_comb begin
    idle_st      = st_r;
    idle_st.mode = M_IDLE;
    idle_emit    = 1'b0;
    idle_res     = '0;
    if (is_space(c)) begin
      idle_st.cur_line = adv_line;
      idle_st.cur_col  = adv_col;
    end else if (c == CH_NUL) begin
      idle_st.tok_line = st_r.cur_line;
      idle_st.tok_col  = st_r.cur_col;
      idle_emit        = 1'b1;
      idle_res         = mk(K_EOF, CH_NUL, st_r.cur_line, st_r.cur_col,
                            st_r.cur_line, st_r.cur_col);
      idle_st.cur_line = PosOne;
      idle_st.cur_col  = PosOne;
    end else if (c == CH_SEMI) begin
      idle_st.cur_line = adv_line;
      idle_st.cur_col  = adv_col;
      idle_st.mode     = M_COMMENT;
    end else begin
      idle_st.tok_line = st_r.cur_line;
      idle_st.tok_col  = st_r.cur_col;
      idle_st.cur_line = adv_line;
      idle_st.cur_col  = adv_col;
      unique case (c)
        CH_LPAREN: begin
          idle_emit = 1'b1;
          idle_res  = mk(K_LPAREN, CH_NUL, st_r.cur_line, st_r.cur_col, adv_line, adv_col);
        end
        CH_RPAREN: begin
          idle_emit = 1'b1;
          idle_res  = mk(K_RPAREN, CH_NUL, st_r.cur_line, st_r.cur_col, adv_line, adv_col);
        end
        CH_QUOTE: begin
          idle_emit = 1'b1;
          idle_res  = mk(K_QUOTE, CH_NUL, st_r.cur_line, st_r.cur_col, adv_line, adv_col);
        end
        CH_BTICK: begin
          idle_emit = 1'b1;
          idle_res  = mk(K_QUASI, CH_NUL, st_r.cur_line, st_r.cur_col, adv_line, adv_col);
        end
        CH_COMMA:  idle_st.mode = M_COMMA;
        CH_DOT:    idle_st.mode = M_DOT;
        CH_DQUOTE: begin
          idle_st.mode    = M_STRING;
          idle_st.str_cnt = '0;
        end
        default: begin
          idle_st.mode   = M_WORD;
          idle_st.wlen   = 2'd1;
          idle_st.wminus = (c == CH_MINUS);
          idle_st.wnum   = is_digit(c);
          idle_emit      = 1'b1;
          idle_res       = mk(K_CONTENT, c, st_r.cur_line, st_r.cur_col, adv_line, adv_col);
        end
      endcase
    end
  end

  always_comb begin
    st_nxt   = st_r;
    pre_v    = 1'b0;
    pre      = '0;
    sec_v    = 1'b0;
    sec      = '0;
    use_idle = 1'b0;
    unique case (st_r.mode)
      M_COMMENT: begin
        if (c == CH_NUL) begin
          use_idle = 1'b1;
        end else begin
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          if (c == CH_LF) st_nxt.mode = M_IDLE;
        end
      end
      M_WORD: begin
        if (ends_word(c)) begin
          pre_v    = 1'b1;
          pre      = mk(st_r.wnum ? K_NUMBER : K_SYMBOL, CH_NUL, st_r.tok_line,
                        st_r.tok_col, st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end else begin
          if ((st_r.wlen == 2'd1) && st_r.wminus && is_digit(c)) st_nxt.wnum = 1'b1;
          if (st_r.wlen < 2'd2) st_nxt.wlen = st_r.wlen + 2'd1;
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          pre_v = 1'b1;
          pre   = mk(K_CONTENT, c, st_r.tok_line, st_r.tok_col, adv_line, adv_col);
        end
      end
      M_DOT: begin
        if (ends_word(c)) begin
          pre_v    = 1'b1;
          pre      = mk(K_DOT, CH_NUL, st_r.tok_line, st_r.tok_col,
                        st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end else begin
          // the dot becomes the first character of a symbol
          pre_v  = 1'b1;
          pre    = mk(K_CONTENT, CH_DOT, st_r.tok_line, st_r.tok_col,
                      st_r.cur_line, st_r.cur_col);
          sec_v  = 1'b1;
          sec    = mk(K_CONTENT, c, st_r.tok_line, st_r.tok_col, adv_line, adv_col);
          st_nxt.mode     = M_WORD;
          st_nxt.wlen     = 2'd2;
          st_nxt.wminus   = 1'b0;
          st_nxt.wnum     = 1'b0;
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
        end
      end
      M_COMMA: begin
        pre_v = 1'b1;
        if (c == CH_AT) begin
          pre             = mk(K_SPLICE, CH_NUL, st_r.tok_line, st_r.tok_col,
                               adv_line, adv_col);
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          st_nxt.mode     = M_IDLE;
        end else begin
          pre      = mk(K_UNQUOTE, CH_NUL, st_r.tok_line, st_r.tok_col,
                        st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_NUL) begin
          pre_v    = 1'b1;
          pre      = mk(K_UNTERM, CH_NUL, st_r.tok_line, st_r.tok_col,
                        st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end else if (c == CH_DQUOTE) begin
          pre_v           = 1'b1;
          pre             = mk(K_STRING, CH_NUL, st_r.tok_line, st_r.tok_col,
                               adv_line, adv_col);
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          st_nxt.mode     = M_IDLE;
        end else if (st_r.str_cnt >= CntMax) begin
          // overflow byte is retokenized from idle
          pre_v    = 1'b1;
          pre      = mk(K_TOOLONG, CH_NUL, st_r.tok_line, st_r.tok_col,
                        st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end else if (c == CH_BSLASH) begin
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          st_nxt.mode     = M_ESCAPE;
        end else begin
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          st_nxt.str_cnt  = st_r.str_cnt + CntW'(1);
          pre_v = 1'b1;
          pre   = mk(K_CONTENT, c, st_r.tok_line, st_r.tok_col, adv_line, adv_col);
        end
      end
      M_ESCAPE: begin
        pre_v = 1'b1;
        if (c == CH_NUL) begin
          pre      = mk(K_UNTERM, CH_NUL, st_r.tok_line, st_r.tok_col,
                        st_r.cur_line, st_r.cur_col);
          use_idle = 1'b1;
        end else begin
          pre             = mk(K_CONTENT, esc_byte, st_r.tok_line, st_r.tok_col,
                               adv_line, adv_col);
          st_nxt.cur_line = adv_line;
          st_nxt.cur_col  = adv_col;
          st_nxt.str_cnt  = st_r.str_cnt + CntW'(1);
          st_nxt.mode     = M_STRING;
        end
      end
      default: use_idle = 1'b1;
    endcase
    if (use_idle) begin
      st_nxt = idle_st;
      sec_v  = idle_emit;
      sec    = idle_res;
    end
  end

  // pack results in order and flag the last one
  always_comb begin
    step_o = '0;
    if (pre_v && sec_v) begin
      step_o.count            = 2'd2;
      step_o.res0             = pre;
      step_o.res1             = sec;
      step_o.res1.last_result = 1'b1;
    end else if (pre_v || sec_v) begin
      step_o.count            = 2'd1;
      step_o.res0             = pre_v ? pre : sec;
      step_o.res0.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= M_IDLE;
      st_r.cur_line <= PosOne;
      st_r.cur_col  <= PosOne;
      st_r.tok_line <= PosOne;
      st_r.tok_col  <= PosOne;
      st_r.str_cnt  <= '0;
      st_r.wlen     <= 2'd0;
      st_r.wminus   <= 1'b0;
      st_r.wnum     <= 1'b0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/core/sxl_outq.sv =====
module sxl_outq
  import sxl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  step_out_t push_i,
  input  logic      pop,
  output res_t      head,
  output logic      not_empty,
  output logic      room
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  res_t            q_r [QDepth];
  logic [PtrW-1:0] wr_r, rd_r, wr_nxt, rd_nxt, wr_p1;
  logic [CntW-1:0] cnt_r, cnt_nxt, n_push;
  logic            do_pop;

  assign n_push    = push_en ? CntW'(push_i.count) : '0;
  assign do_pop    = pop && (cnt_r != '0);
  assign wr_p1     = wr_r + PtrW'(1);
  assign wr_nxt    = wr_r + PtrW'(n_push);
  assign rd_nxt    = do_pop ? rd_r + PtrW'(1) : rd_r;
  assign cnt_nxt   = cnt_r + n_push - (do_pop ? CntW'(1) : '0);
  assign head      = q_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign room      = (cnt_r <= CntW'(QDepth - 2));

  always_ff @(posedge clk) begin
    if (n_push != '0) q_r[wr_r] <= push_i.res0;
    if (n_push == CntW'(2)) q_r[wr_p1] <= push_i.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/sexpr_lexer.sv =====
// Results: each result is registered in the result queue before it appears on out_*.
// Throughput: one byte per cycle while out_ready is high and each byte yields at most one
// result; bytes yielding two results are limited by the one-result-per-cycle output port
// draining a four-entry result queue (in_ready drops with over two queued).
// Reset: synchronous, active low; cursor and token start go to line 1, column 1,
// the lexer returns to idle and the result queue empties.
module sexpr_lexer
  import sxl_pkg::*;
#(
  parameter int MAX_STRING = 1023,
  parameter int POS_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_content_byte,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_col,
  output logic [15:0] out_end_line,
  output logic [15:0] out_end_col,
  output logic        out_last_result
);

  // A transaction on the input is one source byte. The step unit decodes it
  // against the current lexer mode in a single pass and updates the mode,
  // cursor and token start registers at the same edge.
  logic      in_xfer;
  step_out_t step;
  res_t      head;
  logic      q_room;

  assign in_xfer  = in_valid && in_ready;
  // in_ready is high only while the queue has room for two results, so any accepted byte fits.
  assign in_ready = q_room;

  sxl_step #(
    .MAX_STRING (MAX_STRING),
    .POS_BITS   (POS_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .char_byte (in_char_byte),
    .step_o    (step)
  );

  // Results (zero, one or two per byte) are queued in order; the queue head
  // drives the result channel directly from flops.
  sxl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_xfer),
    .push_i    (step),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room      (q_room)
  );

  assign out_kind         = head.kind;
  assign out_content_byte = head.content_byte;
  assign out_start_line   = head.start_line;
  assign out_start_col    = head.start_col;
  assign out_end_line     = head.end_line;
  assign out_end_col      = head.end_col;
  assign out_last_result  = head.last_result;

endmodule

// ===== rtl/core/sxl_checker.sv =====
`include "sexpr_lexer_assert.svh"

module sxl_checker
  import sxl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [7:0]  out_content_byte,
  input logic [15:0] out_start_line,
  input logic [15:0] out_start_col,
  input logic [15:0] out_end_line,
  input logic [15:0] out_end_col,
  input logic        out_last_result
);

  // stalled input byte holds
  `SXL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_char_byte), "input changed while stalled")
  // stalled result keeps its kind and end column
  `SXL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_end_col), "result changed while stalled")
  // only content carries a byte
  `SXL_ASSERT_NOW(a_tok_no_byte, out_valid && (out_kind != K_CONTENT), out_content_byte == 8'd0, "token record with nonzero byte")
  // eof is always the final result of its byte
  `SXL_ASSERT_NOW(a_eof_last, out_valid && (out_kind == K_EOF), out_last_result, "eof not last result")
  // eof is zero width
  `SXL_ASSERT_NOW(a_eof_span, out_valid && (out_kind == K_EOF), (out_start_line == out_end_line) && (out_start_col == out_end_col), "eof start differs from end")

endmodule

bind sexpr_lexer sxl_checker u_sxl_checker (.*);
